FILE: hdl/lkic_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the lru keyed image cache
// no dependencies; used by controller, datapath and top level

package lkic_pkg;

    // field widths fixed by the stream format
    localparam int KEY_WORDS    = 8;
    localparam int KEY_W        = 32 * KEY_WORDS;
    localparam int HANDLE_W     = 32;
    localparam int COUNTER_W    = 64;
    localparam int TOTAL_W      = 8;
    localparam int CAP_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int S_TDATA_W    = 296;
    localparam int M_TDATA_W    = 168;

    // positions in the input word
    localparam int FH_LO        = KEY_W;
    localparam int FV_POS       = KEY_W + HANDLE_W;

    // positions in the output word
    localparam int HT_LO        = HANDLE_W;
    localparam int RT_LO        = HANDLE_W + COUNTER_W;
    localparam int ET_LO        = HANDLE_W + 2 * COUNTER_W;

    // command kinds
    typedef enum logic [1:0] {
        KIND_LOOKUP  = 2'd0,
        KIND_FILL    = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_CNT_RST = 2'd3
    } kind_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;

    // what a scan over the entry memory does
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_SEARCH  = 3'd1,
        OP_PROMOTE = 3'd2,
        OP_INSERT  = 3'd3,
        OP_CLEAR   = 3'd4
    } pass_op_t;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     start;
        pass_op_t op;
        logic     clear_count;
        logic     write_new;
        logic     finish;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic  pass_done;
        logic  found;
        kind_t kind;
        logic  fill_valid;
        logic  enable;
        logic  out_busy;
    } sts_t;

endpackage

FILE: hdl/lru_keyed_image_cache.sv
`timescale 1ns / 1ps
// top level of the lru keyed image cache: controller plus datapath
// depends on lkic_pkg, lkic_controller, lkic_datapath
//
// Usage:
//   s_* takes one command word: kind in s_tuser, key, fill handle and fill
//   valid in s_tdata. m_* returns one result word per command: hit in
//   m_tuser, handle, both counters and entry count in m_tdata.
//   cfg_we/cfg_index/cfg_data write cache_enable (0) and capacity_limit (1)
//   while the block is idle; a capacity of 0 is stored as 1.
// Timing:
//   one memory row is scanned a cycle; a counter reset or a disabled or invalid
//   command goes straight to the result, a lookup miss or a clear runs one
//   scan, a hit or a refill runs a search scan and a promote scan, and an
//   inserting fill runs a search scan, an insert scan and a new-entry write.
// Reset:
//   after rst_n rises, a sweep over every row invalidates all entries
//   before s_tready goes high; counters start at zero.
// Stall:
//   the result sits in an output register; the next command word is taken
//   while it waits, and that command's result holds until m_tready.

module lru_keyed_image_cache
#(
    parameter int ENTRIES = 128
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // key_width, key_height, key_offset_x, key_offset_y, key_blur,
    // key_spread, key_corner, key_scale, fill_handle, fill_valid
    input  logic [lkic_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // image_handle, hit_total, render_total, entry_total
    output logic [lkic_pkg::M_TDATA_W-1:0]    m_tdata,
    // hit
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [lkic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lkic_pkg::CAP_W-1:0]        cfg_data
);

    lkic_pkg::ctl_t ctl;
    lkic_pkg::sts_t sts;

    // sequencer
    lkic_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ctl      (ctl),
        .sts      (sts)
    );

    // storage and arithmetic
    lkic_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tdata   (s_tdata),
        .in_tuser   (s_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ctl        (ctl),
        .sts        (sts),
        .out_tvalid (m_tvalid),
        .out_tready (m_tready),
        .out_tdata  (m_tdata),
        .out_tuser  (m_tuser)
    );

endmodule

FILE: hdl/lkic_controller.sv
`timescale 1ns / 1ps
// sequencer of the lru keyed image cache: issues scans and result writes
// depends on lkic_pkg

module lkic_controller
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output lkic_pkg::ctl_t ctl,
    input  lkic_pkg::sts_t sts
);

    typedef enum logic [9:0] {
        ST_BOOT    = 10'b0000000001,
        ST_WIPE    = 10'b0000000010,
        ST_IDLE    = 10'b0000000100,
        ST_DECODE  = 10'b0000001000,
        ST_SEARCH  = 10'b0000010000,
        ST_PROMOTE = 10'b0000100000,
        ST_INSERT  = 10'b0001000000,
        ST_WRITE   = 10'b0010000000,
        ST_CLEAR   = 10'b0100000000,
        ST_DONE    = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        ctl             = '0;
        ctl.op          = lkic_pkg::OP_NONE;
        case (state_reg)
            ST_BOOT:
            begin
                ctl.start  = 1'b1;
                state_next = ST_WIPE;
            end
            ST_WIPE:
            begin
                ctl.op = lkic_pkg::OP_CLEAR;
                if (sts.pass_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.kind)
                    lkic_pkg::KIND_LOOKUP:
                    begin
                        if (sts.enable)
                        begin
                            ctl.start  = 1'b1;
                            state_next = ST_SEARCH;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    lkic_pkg::KIND_FILL:
                    begin
                        if (sts.enable && sts.fill_valid)
                        begin
                            ctl.start  = 1'b1;
                            state_next = ST_SEARCH;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    lkic_pkg::KIND_CLEAR:
                    begin
                        ctl.start       = 1'b1;
                        ctl.clear_count = 1'b1;
                        state_next      = ST_CLEAR;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SEARCH:
            begin
                ctl.op = lkic_pkg::OP_SEARCH;
                if (sts.pass_done)
                begin
                    if (sts.found)
                    begin
                        ctl.start  = 1'b1;
                        state_next = ST_PROMOTE;
                    end
                    else if (sts.kind == lkic_pkg::KIND_FILL)
                    begin
                        ctl.start  = 1'b1;
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PROMOTE:
            begin
                ctl.op = lkic_pkg::OP_PROMOTE;
                if (sts.pass_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_INSERT:
            begin
                ctl.op = lkic_pkg::OP_INSERT;
                if (sts.pass_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ctl.write_new = 1'b1;
                state_next    = ST_DONE;
            end
            ST_CLEAR:
            begin
                ctl.op = lkic_pkg::OP_CLEAR;
                if (sts.pass_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_BOOT;
            end
        endcase
    end

endmodule

FILE: hdl/lkic_datapath.sv
`timescale 1ns / 1ps
// entry memory, scan pipeline, counters, config and output register
// depends on lkic_pkg

module lkic_datapath
#(
    parameter int ENTRIES = 128
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lkic_pkg::S_TDATA_W-1:0]    in_tdata,
    input  logic [1:0]                        in_tuser,
    input  logic                              cfg_we,
    input  logic [lkic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lkic_pkg::CAP_W-1:0]        cfg_data,
    input  lkic_pkg::ctl_t                    ctl,
    output lkic_pkg::sts_t                    sts,
    output logic                              out_tvalid,
    input  logic                              out_tready,
    output logic [lkic_pkg::M_TDATA_W-1:0]    out_tdata,
    output logic                              out_tuser
);

    localparam int AW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW       = AW;
    localparam int CW       = $clog2(ENTRIES + 1);
    localparam int MW       = ((CW > 8) ? CW : 8) + 1;
    localparam int KEY_W    = lkic_pkg::KEY_W;
    localparam int HW       = lkic_pkg::HANDLE_W;
    localparam int H_LO     = KEY_W;
    localparam int R_LO     = KEY_W + HW;
    localparam int V_POS    = KEY_W + HW + RW;
    localparam int ROW_W    = V_POS + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
    localparam logic [7:0]    CAP_MAX   = 8'((ENTRIES > 255) ? 255 : ENTRIES);
    localparam logic [7:0]    CAP_RST   = 8'((ENTRIES < 128) ? ENTRIES : 128);

    // item registers
    lkic_pkg::kind_t   kind_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [HW-1:0]     fh_reg;
    logic              fv_reg;

    // config registers
    logic              en_reg;
    logic [7:0]        cap_reg;
    logic [7:0]        cap_wr;

    // scan pipeline
    logic [AW-1:0]     scan_addr_reg;
    logic              issue_reg;
    logic              pend_reg;
    logic [AW-1:0]     pend_addr_reg;

    // entry memory
    logic [ROW_W-1:0]  mem [ENTRIES];
    logic [ROW_W-1:0]  rd_data_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [ROW_W-1:0]  wr_row;

    // search and insert results
    logic              found_reg;
    logic [AW-1:0]     idx_reg;
    logic [RW-1:0]     frank_reg;
    logic [HW-1:0]     hit_handle_reg;
    logic              slot_found_reg;
    logic [AW-1:0]     slot_reg;

    // counters
    logic [CW-1:0]     count_reg;
    logic [63:0]       hit_cnt_reg;
    logic [63:0]       ren_cnt_reg;
    logic [63:0]       hit_cnt_next;
    logic [63:0]       ren_cnt_next;

    // output register
    logic                           out_valid_reg;
    logic                           out_hit_reg;
    logic [lkic_pkg::M_TDATA_W-1:0] out_data_reg;

    // fields of the row just read
    logic              rv;
    logic [RW-1:0]     rr;
    logic [HW-1:0]     rh;
    logic [KEY_W-1:0]  rk;
    logic              evict_now;
    logic              rank_old;
    logic              post_free;
    logic              hit_now;
    logic [HW-1:0]     handle_out;
    logic [CW-1:0]     count_base;

    assign rv = rd_data_reg[V_POS];
    assign rr = rd_data_reg[R_LO +: RW];
    assign rh = rd_data_reg[H_LO +: HW];
    assign rk = rd_data_reg[KEY_W-1:0];

    // eviction applies when the cache is at or over capacity
    assign evict_now  = MW'(count_reg) >= MW'(cap_reg);
    assign rank_old   = MW'(rr) >= (MW'(cap_reg) - MW'(1));
    assign post_free  = !rv || (evict_now && rank_old);
    assign count_base = evict_now ? CW'(cap_reg - 8'd1) : count_reg;

    // capacity clamp on write
    assign cap_wr = (cfg_data == 8'd0) ? 8'd1 :
                    ((cfg_data > CAP_MAX) ? CAP_MAX : cfg_data);

    // write-back row of the scan, or the new entry
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_row  = rd_data_reg;
        if (ctl.write_new)
        begin
            wr_en                = 1'b1;
            wr_addr              = slot_reg;
            wr_row[KEY_W-1:0]    = key_reg;
            wr_row[H_LO +: HW]   = fh_reg;
            wr_row[R_LO +: RW]   = '0;
            wr_row[V_POS]        = 1'b1;
        end
        else if (pend_reg)
        begin
            case (ctl.op)
                lkic_pkg::OP_PROMOTE:
                begin
                    wr_en = 1'b1;
                    if (pend_addr_reg == idx_reg)
                    begin
                        wr_row[R_LO +: RW] = '0;
                        if (kind_reg == lkic_pkg::KIND_FILL)
                        begin
                            wr_row[H_LO +: HW] = fh_reg;
                        end
                    end
                    else if (rv && (rr < frank_reg))
                    begin
                        wr_row[R_LO +: RW] = rr + 1'b1;
                    end
                end
                lkic_pkg::OP_INSERT:
                begin
                    wr_en = 1'b1;
                    if (rv)
                    begin
                        if (evict_now && rank_old)
                        begin
                            wr_row[V_POS] = 1'b0;
                        end
                        else
                        begin
                            wr_row[R_LO +: RW] = rr + 1'b1;
                        end
                    end
                end
                lkic_pkg::OP_CLEAR:
                begin
                    wr_en         = 1'b1;
                    wr_row[V_POS] = 1'b0;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // entry memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (issue_reg)
        begin
            rd_data_reg <= mem[scan_addr_reg];
        end
    end

    // item capture and search bookkeeping
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            kind_reg <= lkic_pkg::kind_t'(in_tuser);
            key_reg  <= in_tdata[KEY_W-1:0];
            fh_reg   <= in_tdata[lkic_pkg::FH_LO +: HW];
            fv_reg   <= in_tdata[lkic_pkg::FV_POS];
        end
        if (pend_reg && (ctl.op == lkic_pkg::OP_SEARCH) && !found_reg && rv && (rk == key_reg))
        begin
            idx_reg        <= pend_addr_reg;
            frank_reg      <= rr;
            hit_handle_reg <= rh;
        end
        if (pend_reg && (ctl.op == lkic_pkg::OP_INSERT) && !slot_found_reg && post_free)
        begin
            slot_reg <= pend_addr_reg;
        end
    end

    // scan control and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg  <= '0;
            issue_reg      <= 1'b0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            found_reg      <= 1'b0;
            slot_found_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= issue_reg;
            pend_addr_reg <= scan_addr_reg;
            if (ctl.start)
            begin
                scan_addr_reg  <= '0;
                issue_reg      <= 1'b1;
                slot_found_reg <= 1'b0;
            end
            else if (issue_reg)
            begin
                if (scan_addr_reg == LAST_ADDR)
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
            end
            if (ctl.load)
            begin
                found_reg <= 1'b0;
            end
            else if (pend_reg && (ctl.op == lkic_pkg::OP_SEARCH) && rv && (rk == key_reg))
            begin
                found_reg <= 1'b1;
            end
            if (pend_reg && (ctl.op == lkic_pkg::OP_INSERT) && post_free)
            begin
                slot_found_reg <= 1'b1;
            end
        end
    end

    // result values
    assign hit_now = (kind_reg == lkic_pkg::KIND_LOOKUP) && found_reg;

    always_comb
    begin
        hit_cnt_next = hit_cnt_reg;
        ren_cnt_next = ren_cnt_reg;
        handle_out   = '0;
        case (kind_reg)
            lkic_pkg::KIND_LOOKUP:
            begin
                if (hit_now)
                begin
                    hit_cnt_next = hit_cnt_reg + 64'd1;
                    handle_out   = hit_handle_reg;
                end
            end
            lkic_pkg::KIND_FILL:
            begin
                ren_cnt_next = ren_cnt_reg + 64'd1;
                if (fv_reg)
                begin
                    handle_out = fh_reg;
                end
            end
            lkic_pkg::KIND_CNT_RST:
            begin
                hit_cnt_next = '0;
                ren_cnt_next = '0;
            end
            default:
            begin
                handle_out = '0;
            end
        endcase
    end

    // config, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg        <= 1'b1;
            cap_reg       <= CAP_RST;
            count_reg     <= '0;
            hit_cnt_reg   <= '0;
            ren_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lkic_pkg::CFG_ENABLE:   en_reg  <= cfg_data[0];
                    lkic_pkg::CFG_CAPACITY: cap_reg <= cap_wr;
                    default:                en_reg  <= en_reg;
                endcase
            end
            if (ctl.clear_count)
            begin
                count_reg <= '0;
            end
            else if (ctl.write_new)
            begin
                count_reg <= count_base + 1'b1;
            end
            if (ctl.finish)
            begin
                hit_cnt_reg   <= hit_cnt_next;
                ren_cnt_reg   <= ren_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            out_hit_reg                                   <= hit_now;
            out_data_reg[HW-1:0]                          <= handle_out;
            out_data_reg[lkic_pkg::HT_LO +: 64]           <= hit_cnt_next;
            out_data_reg[lkic_pkg::RT_LO +: 64]           <= ren_cnt_next;
            out_data_reg[lkic_pkg::ET_LO +: 8]            <= 8'(count_reg);
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_data_reg;
    assign out_tuser  = out_hit_reg;

    // status to the controller
    assign sts.pass_done  = !issue_reg && !pend_reg;
    assign sts.found      = found_reg;
    assign sts.kind       = kind_reg;
    assign sts.fill_valid = fv_reg;
    assign sts.enable     = en_reg;
    assign sts.out_busy   = out_valid_reg && !out_tready;

endmodule
